>>> sv/euler_world_matrix_assert.svh
// Assertion macros for the files that check themselves.
`ifndef EULER_WORLD_MATRIX_ASSERT_SVH
`define EULER_WORLD_MATRIX_ASSERT_SVH

// Checked only outside reset.
`define EWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked in every cycle, reset included.
`define EWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/ewm_pkg.sv
package ewm_pkg;

    // Number of register stages from the input register to the output register.
    localparam int CORDIC_STEPS = 24;
    localparam int NUM_STAGES   = CORDIC_STEPS + 9;

    // Stage indices of interest.
    localparam int ST_CORDIC0 = 3;
    localparam int ST_CLAMP   = ST_CORDIC0 + CORDIC_STEPS;
    localparam int ST_PROD1   = ST_CLAMP + 1;
    localparam int ST_PROD2   = ST_PROD1 + 1;
    localparam int ST_SUM     = ST_PROD2 + 1;
    localparam int ST_SCALE   = ST_SUM + 1;
    localparam int ST_OUT     = ST_SCALE + 1;

    // Angle constants in Q30 radians.
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] TRIG_ONE    = 34'sd1073741824;
    localparam logic signed [63:0] TRIG_HALF   = 64'sd536870912;
    localparam logic signed [64:0] SCALE_HALF  = 65'sd536870912;

    typedef logic signed [33:0] cord_t;
    typedef logic signed [31:0] trig_t;

    // Payload that travels beside the arithmetic.
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] scale;
        logic [2:0]       flip;
    } carry_t;

    // Arctangent of 2^-i in Q30.
    function automatic cord_t atan_q30(input int i);
        cord_t r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q30 by Q30 product, rounded half up.
    function automatic trig_t mul30(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = a * b;
        p = p + TRIG_HALF;
        return p[61:30];
    endfunction

endpackage

>>> sv/euler_world_matrix.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | transform, 240 bits
// m_      | out       | m_tvalid/m_tready  | world matrix rows, 384 bits
//
// One transaction per cycle is accepted unless the output holds an untaken result.
// The pipeline holds the 24-step CORDIC plus reduction and products.
// Reset (aresetn low, synchronous) clears all valid bits; data needs none.
// When the output holds an untaken result the whole pipeline holds.
module euler_world_matrix (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // w00, w01, w02, w10, w11, w12, w20, w21, w22, w30, w31, w32
    output logic [383:0] m_tdata
);
    import ewm_pkg::*;

    `include "euler_world_matrix_assert.svh"

    logic                     adv;
    logic [NUM_STAGES-1:0]    vld_reg;
    carry_t                   carry_reg [NUM_STAGES];

    logic signed [15:0]       ang_reg [3];
    logic signed [35:0]       red_reg [3];
    logic signed [35:0]       red_next [3];
    cord_t                    z0_next [3];
    logic [2:0]               flip_next;
    cord_t                    z0_reg [3];

    cord_t                    cx_reg [CORDIC_STEPS][3];
    cord_t                    cy_reg [CORDIC_STEPS][3];
    cord_t                    cz_reg [CORDIC_STEPS][3];
    cord_t                    cx_next [CORDIC_STEPS][3];
    cord_t                    cy_next [CORDIC_STEPS][3];
    cord_t                    cz_next [CORDIC_STEPS][3];

    trig_t                    sin_reg [3];
    trig_t                    cos_reg [3];
    trig_t                    sin_next [3];
    trig_t                    cos_next [3];

    // First product stage: pair products and carried terms.
    trig_t sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg, cxcz_reg;
    trig_t sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg, sy1_reg, cz1_reg, sz1_reg;
    // Second product stage.
    trig_t ma_reg, mb_reg, mc_reg, md_reg;
    trig_t cycz2_reg, cysz2_reg, sy2_reg, cxsz2_reg, cxcz2_reg;
    trig_t sxcy2_reg, sxsz2_reg, sxcz2_reg, cxcy2_reg;
    logic signed [32:0]       r_reg [9];
    logic signed [64:0]       prod_reg [9];
    logic [31:0]              w_reg [9];
    logic [31:0]              w_next [9];

    // The pipeline moves whenever the output register is free or being taken.
    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NUM_STAGES-1];

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    // Range reduction into [-pi, pi] by at most two turns.
    always_comb begin
        logic signed [35:0] a;
        for (int k = 0; k < 3; k++) begin
            a = 36'(ang_reg[k]) <<< 18;
            for (int n = 0; n < 2; n++) begin
                if (a > PI_Q30) begin
                    a = a - TWO_PI_Q30;
                end else if (a < -PI_Q30) begin
                    a = a + TWO_PI_Q30;
                end
            end
            red_next[k] = a;
        end
    end

    // Fold into [-pi/2, pi/2], remembering a sign flip.
    always_comb begin
        logic signed [35:0] a;
        for (int k = 0; k < 3; k++) begin
            a = red_reg[k];
            flip_next[k] = 1'b0;
            if (a > HALF_PI_Q30) begin
                a = a - PI_Q30;
                flip_next[k] = 1'b1;
            end else if (a < -HALF_PI_Q30) begin
                a = a + PI_Q30;
                flip_next[k] = 1'b1;
            end
            z0_next[k] = a[33:0];
        end
    end

    // CORDIC rotation, one step per stage for all three angles.
    always_comb begin
        cord_t x, y, z;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (i == 0) begin
                    x = CORDIC_GAIN;
                    y = '0;
                    z = z0_reg[k];
                end else begin
                    x = cx_reg[i-1][k];
                    y = cy_reg[i-1][k];
                    z = cz_reg[i-1][k];
                end
                if (!z[33]) begin
                    cx_next[i][k] = x - (y >>> i);
                    cy_next[i][k] = y + (x >>> i);
                    cz_next[i][k] = z - atan_q30(i);
                end else begin
                    cx_next[i][k] = x + (y >>> i);
                    cy_next[i][k] = y - (x >>> i);
                    cz_next[i][k] = z + atan_q30(i);
                end
            end
        end
    end

    // Undo the fold and clamp to [-1, 1].
    always_comb begin
        cord_t c, s;
        for (int k = 0; k < 3; k++) begin
            c = cx_reg[CORDIC_STEPS-1][k];
            s = cy_reg[CORDIC_STEPS-1][k];
            if (carry_reg[ST_CLAMP-1].flip[k]) begin
                c = -c;
                s = -s;
            end
            if (c > TRIG_ONE) c = TRIG_ONE;
            if (c < -TRIG_ONE) c = -TRIG_ONE;
            if (s > TRIG_ONE) s = TRIG_ONE;
            if (s < -TRIG_ONE) s = -TRIG_ONE;
            cos_next[k] = c[31:0];
            sin_next[k] = s[31:0];
        end
    end

    // Rounding and saturation of the scaled entries.
    always_comb begin
        logic signed [64:0] v;
        logic signed [34:0] sh;
        for (int k = 0; k < 9; k++) begin
            v  = prod_reg[k] + SCALE_HALF;
            sh = v[64:30];
            if (sh > 35'sd2147483647) begin
                w_next[k] = 32'h7FFF_FFFF;
            end else if (sh < -35'sd2147483648) begin
                w_next[k] = 32'h8000_0000;
            end else begin
                w_next[k] = sh[31:0];
            end
        end
    end

    // Data path registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            carry_reg[0].pos   <= s_tdata[95:0];
            carry_reg[0].scale <= s_tdata[239:144];
            carry_reg[0].flip  <= '0;
            for (int n = 1; n < NUM_STAGES; n++) begin
                if (n == 2) begin
                    carry_reg[n].pos   <= carry_reg[n-1].pos;
                    carry_reg[n].scale <= carry_reg[n-1].scale;
                    carry_reg[n].flip  <= flip_next;
                end else begin
                    carry_reg[n] <= carry_reg[n-1];
                end
            end

            ang_reg[0] <= s_tdata[111:96];
            ang_reg[1] <= s_tdata[127:112];
            ang_reg[2] <= s_tdata[143:128];
            for (int k = 0; k < 3; k++) begin
                red_reg[k] <= red_next[k];
                z0_reg[k]  <= z0_next[k];
                sin_reg[k] <= sin_next[k];
                cos_reg[k] <= cos_next[k];
            end
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;

            sxsy_reg <= mul30(sin_reg[0], sin_reg[1]);
            cxsy_reg <= mul30(cos_reg[0], sin_reg[1]);
            cycz_reg <= mul30(cos_reg[1], cos_reg[2]);
            cysz_reg <= mul30(cos_reg[1], sin_reg[2]);
            cxsz_reg <= mul30(cos_reg[0], sin_reg[2]);
            cxcz_reg <= mul30(cos_reg[0], cos_reg[2]);
            sxcy_reg <= mul30(sin_reg[0], cos_reg[1]);
            sxsz_reg <= mul30(sin_reg[0], sin_reg[2]);
            sxcz_reg <= mul30(sin_reg[0], cos_reg[2]);
            cxcy_reg <= mul30(cos_reg[0], cos_reg[1]);
            sy1_reg  <= sin_reg[1];
            cz1_reg  <= cos_reg[2];
            sz1_reg  <= sin_reg[2];

            ma_reg    <= mul30(sxsy_reg, cz1_reg);
            mb_reg    <= mul30(sxsy_reg, sz1_reg);
            mc_reg    <= mul30(cxsy_reg, cz1_reg);
            md_reg    <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            sy2_reg   <= sy1_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcy2_reg <= sxcy_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            cxcy2_reg <= cxcy_reg;

            // Rotation matrix entries.
            r_reg[0] <= 33'(cycz2_reg);
            r_reg[1] <= -33'(cysz2_reg);
            r_reg[2] <= 33'(sy2_reg);
            r_reg[3] <= 33'(ma_reg) + 33'(cxsz2_reg);
            r_reg[4] <= 33'(cxcz2_reg) - 33'(mb_reg);
            r_reg[5] <= -33'(sxcy2_reg);
            r_reg[6] <= 33'(sxsz2_reg) - 33'(mc_reg);
            r_reg[7] <= 33'(md_reg) + 33'(sxcz2_reg);
            r_reg[8] <= 33'(cxcy2_reg);

            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= $signed(carry_reg[ST_SUM].scale[k/3]) * r_reg[k];
                w_reg[k]    <= w_next[k];
            end
        end
    end

    // Output packing.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m_tdata[32*k +: 32] = w_reg[k];
        end
        m_tdata[383:288] = carry_reg[NUM_STAGES-1].pos;
    end

    `EWM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "valid survived reset")
    `EWM_ASSERT(a_stall_only_full, !s_tready |-> m_tvalid, "input stalled with empty output")
    `EWM_ASSERT(a_trig_range, vld_reg[ST_CLAMP] |-> (sin_reg[0] <= 32'sd1073741824 && sin_reg[0] >= -32'sd1073741824 && cos_reg[0] <= 32'sd1073741824 && cos_reg[0] >= -32'sd1073741824), "trig out of range")

endmodule
